/* rtl/core/ael_pkg.sv */
// shared types, character codes and limits for the expression lexer
`default_nettype none

package ael_pkg;

	localparam int MANT_W     = 60;
	localparam int FRAC_W     = 5;
	localparam int CNT_W      = 5;
	localparam int MAX_DIGITS = 18;
	localparam int NTOK       = 3;

	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_CARET  = 8'h5e;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;

	typedef enum logic [3:0] {
		K_NUMBER = 4'd0,
		K_MINUS  = 4'd1,
		K_PLUS   = 4'd2,
		K_STAR   = 4'd3,
		K_SLASH  = 4'd4,
		K_CARET  = 4'd5,
		K_LPAREN = 4'd6,
		K_RPAREN = 4'd7,
		K_END    = 4'd8,
		K_ERROR  = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_WS   = 3'd1,
		M_INT  = 3'd2,
		M_DOT  = 3'd3,
		M_FRAC = 3'd4,
		M_SKIP = 3'd5
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [MANT_W-1:0]  acc;
		logic [FRAC_W-1:0]  fc;
		logic [CNT_W-1:0]   dc;
	} scan_t;

	typedef struct packed {
		kind_t              kind;
		logic [MANT_W-1:0]  mant;
		logic [FRAC_W-1:0]  frac;
		logic               last;
	} tok_t;

	localparam scan_t SCAN_RESET = '{mode: M_IDLE, acc: '0, fc: '0, dc: '0};

endpackage

`default_nettype wire

/* rtl/core/ael_step.sv */
// per-character scan logic: next scan state and up to three tokens
`default_nettype none

module ael_step #(
	parameter int MAX_DIGITS = ael_pkg::MAX_DIGITS
) (
	input  wire logic [7:0]            ch,
	input  wire logic                  has,
	input  wire logic                  eoe,
	input  wire ael_pkg::scan_t        st,
	output ael_pkg::scan_t             nst,
	output ael_pkg::tok_t [2:0]        toks,
	output logic [1:0]                 tok_cnt
);

	logic              dig, dot, sp;
	logic              op_ok;
	ael_pkg::kind_t    op_kind;
	logic [63:0]       grown;
	logic              ovf;

	assign dig = (ch >= ael_pkg::CH_0) && (ch <= ael_pkg::CH_9);
	assign dot = (ch == ael_pkg::CH_DOT);
	assign sp  = (ch == ael_pkg::CH_SPACE) || ((ch >= ael_pkg::CH_TAB) && (ch <= ael_pkg::CH_CR));

	// acc * 10 + digit, overflow when it leaves 60 bits or too many digits
	assign grown = ({4'b0, st.acc} << 3) + ({4'b0, st.acc} << 1) + {60'b0, ch[3:0]};
	assign ovf   = (|grown[63:60]) || (st.dc >= ael_pkg::CNT_W'(MAX_DIGITS));

	always_comb begin
		op_ok   = 1'b1;
		op_kind = ael_pkg::K_MINUS;
		unique case (ch)
			ael_pkg::CH_MINUS:  op_kind = ael_pkg::K_MINUS;
			ael_pkg::CH_PLUS:   op_kind = ael_pkg::K_PLUS;
			ael_pkg::CH_STAR:   op_kind = ael_pkg::K_STAR;
			ael_pkg::CH_SLASH:  op_kind = ael_pkg::K_SLASH;
			ael_pkg::CH_CARET:  op_kind = ael_pkg::K_CARET;
			ael_pkg::CH_LPAREN: op_kind = ael_pkg::K_LPAREN;
			ael_pkg::CH_RPAREN: op_kind = ael_pkg::K_RPAREN;
			default:            op_ok   = 1'b0;
		endcase
	end

	ael_pkg::scan_t mid;
	ael_pkg::mode_t md;
	logic           ok, push, push_frac, fl1, opv, fl2, fin;
	ael_pkg::kind_t fin_kind;
	logic [1:0]     n;

	always_comb begin
		mid       = st;
		nst       = st;
		ok        = 1'b1;
		push      = 1'b0;
		push_frac = 1'b0;
		fl1       = 1'b0;
		opv       = 1'b0;
		fl2       = 1'b0;
		fin       = 1'b0;
		fin_kind  = ael_pkg::K_END;
		toks      = '0;
		n         = 2'd0;

		unique case (st.mode)
			ael_pkg::M_WS, ael_pkg::M_INT, ael_pkg::M_DOT,
			ael_pkg::M_FRAC, ael_pkg::M_SKIP: md = st.mode;
			default:                          md = ael_pkg::M_IDLE;
		endcase
		mid.mode = md;

		if (md == ael_pkg::M_SKIP) begin
			if (eoe) begin
				nst = ael_pkg::SCAN_RESET;
			end
		end else begin
			if (has) begin
				unique case (md)
					ael_pkg::M_INT, ael_pkg::M_FRAC: begin
						if (dig) begin
							push      = 1'b1;
							push_frac = (md == ael_pkg::M_FRAC);
						end else if (dot) begin
							if (md == ael_pkg::M_INT) mid.mode = ael_pkg::M_DOT;
							else ok = 1'b0;
						end else begin
							// number closed by this character, then start a new token
							fl1      = 1'b1;
							mid      = ael_pkg::SCAN_RESET;
							if (sp) mid.mode = ael_pkg::M_WS;
							else if (op_ok) opv = 1'b1;
							else ok = 1'b0;
						end
					end
					ael_pkg::M_DOT: begin
						if (dig) begin
							mid.mode  = ael_pkg::M_FRAC;
							push      = 1'b1;
							push_frac = 1'b1;
						end else begin
							ok = 1'b0;
						end
					end
					ael_pkg::M_WS: begin
						if (dig) begin
							mid.mode = ael_pkg::M_INT;
							push     = 1'b1;
						end else if (dot) begin
							mid.mode = ael_pkg::M_DOT;
						end else begin
							ok = 1'b0;
						end
					end
					default: begin
						if (dig) begin
							mid.mode = ael_pkg::M_INT;
							push     = 1'b1;
						end else if (dot) begin
							mid.mode = ael_pkg::M_DOT;
						end else if (sp) begin
							mid.mode = ael_pkg::M_WS;
						end else if (op_ok) begin
							opv = 1'b1;
						end else begin
							ok = 1'b0;
						end
					end
				endcase
			end

			if (push) begin
				if (ovf) begin
					ok = 1'b0;
				end else begin
					mid.acc = grown[59:0];
					mid.dc  = st.dc + 1'b1;
					if (push_frac) mid.fc = st.fc + 1'b1;
				end
			end

			nst = mid;
			if (ok && eoe) begin
				if (mid.mode == ael_pkg::M_INT || mid.mode == ael_pkg::M_FRAC) begin
					fl2 = 1'b1;
				end else if (mid.mode == ael_pkg::M_WS || mid.mode == ael_pkg::M_DOT) begin
					ok = 1'b0;
				end
				if (ok) begin
					fin = 1'b1;
					nst = ael_pkg::SCAN_RESET;
				end
			end
			if (!ok) begin
				fin      = 1'b1;
				fin_kind = ael_pkg::K_ERROR;
				nst      = ael_pkg::SCAN_RESET;
				nst.mode = eoe ? ael_pkg::M_IDLE : ael_pkg::M_SKIP;
			end
		end

		// pack the tokens in emission order
		if (fl1) begin
			toks[n] = '{kind: ael_pkg::K_NUMBER, mant: st.acc, frac: st.fc, last: 1'b0};
			n = n + 2'd1;
		end
		if (opv) begin
			toks[n] = '{kind: op_kind, mant: '0, frac: '0, last: 1'b0};
			n = n + 2'd1;
		end
		if (fl2) begin
			toks[n] = '{kind: ael_pkg::K_NUMBER, mant: mid.acc, frac: mid.fc, last: 1'b0};
			n = n + 2'd1;
		end
		if (fin) begin
			toks[n] = '{kind: fin_kind, mant: '0, frac: '0, last: 1'b1};
			n = n + 2'd1;
		end
		tok_cnt = n;
	end

endmodule

`default_nettype wire

/* rtl/core/arith_expression_lexer.sv */
// streaming tokenizer for arithmetic expressions, top level
// usage:
//   s_* carries one character word per handshake; tdata is the byte, tuser
//   says the byte is real (0 for a bare end mark), tlast closes the expression
//   m_* gives one token word per handshake; tuser is the token kind, tdata
//   holds the mantissa (bits 59:0) and fraction digit count (bits 64:60),
//   tlast marks the end or error token that closes an expression
// path: a character waits in the input register, then its tokens are
//   loaded into a three-entry result buffer, whose head token is offered
//   on m_*; the load waits until the buffer is empty or emptying
// throughput: one character per cycle while each character yields at most
//   one token and m_tready is high; a character that yields more tokens holds
//   the input until the single output port has drained the result buffer
// reset: arst_n clears the scan state, input register and result buffer;
//   the block then waits for the start of a new expression
// stall: while m_tready is low the buffered tokens hold and the input
//   register keeps one more character, after which s_tready drops
`default_nettype none

module arith_expression_lexer #(
	parameter int MAX_DIGITS = ael_pkg::MAX_DIGITS  // digit limit of one number
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// character side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tuser,   // [0] has_char
	input  wire logic        s_tlast,   // end_of_expr
	// token side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [59:0] number_mantissa, [64:60] fraction_digits
	output logic [3:0]       m_tuser,   // [3:0] token_kind
	output logic             m_tlast    // last_token
);

	// input register
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        has_s1;
	logic        end_s1;

	// scan state and result buffer
	ael_pkg::scan_t        st_q;
	ael_pkg::scan_t        st_next;
	ael_pkg::tok_t [2:0]   toks;
	logic [1:0]            tok_cnt;
	ael_pkg::tok_t         bank_q [3];
	logic [1:0]            head_q;
	logic [1:0]            rem_q;
	ael_pkg::tok_t         cur;

	logic pop, load;

	assign pop  = m_tvalid && m_tready;
	// the buffer takes the next character's tokens once it is empty or emptying
	assign load = valid_s1 && ((rem_q == 2'd0) || ((rem_q == 2'd1) && pop));
	assign s_tready = !valid_s1 || load;

	ael_step #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_step (
		.ch      (char_s1),
		.has     (has_s1),
		.eoe     (end_s1),
		.st      (st_q),
		.nst     (st_next),
		.toks    (toks),
		.tok_cnt (tok_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			has_s1  <= s_tuser;
			end_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ael_pkg::SCAN_RESET;
			head_q <= 2'd0;
			rem_q  <= 2'd0;
		end else if (load) begin
			st_q   <= st_next;
			head_q <= 2'd0;
			rem_q  <= tok_cnt;
		end else if (pop) begin
			head_q <= head_q + 2'd1;
			rem_q  <= rem_q - 2'd1;
		end
	end

	// token payload, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			bank_q[0] <= toks[0];
			bank_q[1] <= toks[1];
			bank_q[2] <= toks[2];
		end
	end

	always_comb begin
		unique case (head_q)
			2'd1:    cur = bank_q[1];
			2'd2:    cur = bank_q[2];
			default: cur = bank_q[0];
		endcase
	end

	assign m_tvalid = (rem_q != 2'd0);
	assign m_tdata  = {7'b0, cur.frac, cur.mant};
	assign m_tuser  = cur.kind;
	assign m_tlast  = cur.last;

endmodule

`default_nettype wire

/* tb/tb.sv */
// self-checking testbench for the arithmetic expression lexer
`timescale 1ns / 100ps

module tb;

	localparam int STALL_LIMIT  = 4000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 32;    // settle time after the last token is due
	localparam int RANDOM_WORDS = 280;

	// one character word waiting to be sent
	typedef struct {
		logic [7:0] ch;
		logic       has;
		logic       eoe;
		bit         drain;  // hold this word until every due token has come out
	} char_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
	logic        s_tuser = 1'b0;    // [0] has_char
	logic        s_tlast = 1'b0;    // end_of_expr
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // [59:0] number_mantissa, [64:60] fraction_digits
	logic [3:0]  m_tuser;           // [3:0] token_kind
	logic        m_tlast;           // last_token

	char_word_t     chars_to_send[$];
	ael_pkg::tok_t  tokens_due[$];
	int             bad_tokens = 0;
	int             words_sent = 0;
	int             real_words = 0;
	int             quiet_cycles = 0;
	bit             drain_next = 1'b0;

	// idle profile moves through four phases as words go out:
	// none, sender idle, receiver stalling, both
	logic [1:0] phase;
	int         send_idle_pct;
	int         recv_stall_pct;
	assign phase          = 2'(words_sent / 40);
	assign send_idle_pct  = (phase == 2'd1) ? 64 : (phase == 2'd3) ? 27 : 0;
	assign recv_stall_pct = (phase == 2'd2) ? 64 : (phase == 2'd3) ? 27 : 0;

	arith_expression_lexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// ---------------------------------------------------------------
	// token predictor: its own copy of the scan state
	// ---------------------------------------------------------------
	ael_pkg::mode_t             sc_mode = ael_pkg::M_IDLE;
	logic [ael_pkg::MANT_W-1:0] sc_acc  = '0;
	logic [ael_pkg::FRAC_W-1:0] sc_frac = '0;
	logic [ael_pkg::CNT_W-1:0]  sc_ndig = '0;

	function automatic void queue_token(ael_pkg::kind_t k, logic [ael_pkg::MANT_W-1:0] m,
	                                    logic [ael_pkg::FRAC_W-1:0] f, logic l);
		ael_pkg::tok_t t;
		t.kind = k;
		t.mant = m;
		t.frac = f;
		t.last = l;
		tokens_due.push_back(t);
	endfunction

	function automatic void drop_number();
		sc_acc  = '0;
		sc_frac = '0;
		sc_ndig = '0;
	endfunction

	function automatic void close_number();
		queue_token(ael_pkg::K_NUMBER, sc_acc, sc_frac, 1'b0);
		drop_number();
	endfunction

	// append one digit to the mantissa, 0 on overflow or past the digit limit
	function automatic bit take_digit(logic [7:0] c, bit in_frac);
		logic [63:0] d;
		logic [63:0] top;
		d   = 64'(c - ael_pkg::CH_0);
		top = {{(64-ael_pkg::MANT_W){1'b0}}, {ael_pkg::MANT_W{1'b1}}};
		if (int'(sc_ndig) + 1 > ael_pkg::MAX_DIGITS)
			return 1'b0;
		if ({{(64-ael_pkg::MANT_W){1'b0}}, sc_acc} > (top - d) / 64'd10)
			return 1'b0;
		sc_acc  = ael_pkg::MANT_W'({{(64-ael_pkg::MANT_W){1'b0}}, sc_acc} * 64'd10 + d);
		sc_ndig = sc_ndig + 1'b1;
		if (in_frac)
			sc_frac = sc_frac + 1'b1;
		return 1'b1;
	endfunction

	// character seen with no token open, 0 on error
	function automatic bit open_token(logic [7:0] c);
		ael_pkg::kind_t op;
		op = ael_pkg::K_NUMBER;
		if (c >= ael_pkg::CH_0 && c <= ael_pkg::CH_9) begin
			sc_mode = ael_pkg::M_INT;
			return take_digit(c, 1'b0);
		end
		if (c == ael_pkg::CH_DOT) begin
			sc_mode = ael_pkg::M_DOT;
			return 1'b1;
		end
		if (c == ael_pkg::CH_SPACE || (c >= ael_pkg::CH_TAB && c <= ael_pkg::CH_CR)) begin
			sc_mode = ael_pkg::M_WS;
			return 1'b1;
		end
		case (c)
			ael_pkg::CH_MINUS:  op = ael_pkg::K_MINUS;
			ael_pkg::CH_PLUS:   op = ael_pkg::K_PLUS;
			ael_pkg::CH_STAR:   op = ael_pkg::K_STAR;
			ael_pkg::CH_SLASH:  op = ael_pkg::K_SLASH;
			ael_pkg::CH_CARET:  op = ael_pkg::K_CARET;
			ael_pkg::CH_LPAREN: op = ael_pkg::K_LPAREN;
			ael_pkg::CH_RPAREN: op = ael_pkg::K_RPAREN;
			default:            return 1'b0;
		endcase
		queue_token(op, '0, '0, 1'b0);
		sc_mode = ael_pkg::M_IDLE;
		return 1'b1;
	endfunction

	// one accepted character word: update the scan state, queue its tokens
	function automatic void scan_char(logic [7:0] c, logic has, logic eoe);
		bit ok;
		bit digit;
		ok    = 1'b1;
		digit = (c >= ael_pkg::CH_0 && c <= ael_pkg::CH_9);
		// after an error everything up to the closing word is dropped
		if (sc_mode == ael_pkg::M_SKIP) begin
			if (eoe) begin
				sc_mode = ael_pkg::M_IDLE;
				drop_number();
			end
			return;
		end
		if (has) begin
			case (sc_mode)
				ael_pkg::M_INT: begin
					if (digit)
						ok = take_digit(c, 1'b0);
					else if (c == ael_pkg::CH_DOT)
						sc_mode = ael_pkg::M_DOT;
					else begin
						close_number();
						sc_mode = ael_pkg::M_IDLE;
						ok = open_token(c);
					end
				end
				ael_pkg::M_FRAC: begin
					if (digit)
						ok = take_digit(c, 1'b1);
					else if (c == ael_pkg::CH_DOT)
						ok = 1'b0;  // second point
					else begin
						close_number();
						sc_mode = ael_pkg::M_IDLE;
						ok = open_token(c);
					end
				end
				ael_pkg::M_DOT: begin
					if (digit) begin
						sc_mode = ael_pkg::M_FRAC;
						ok = take_digit(c, 1'b1);
					end else
						ok = 1'b0;  // point with no digit after it
				end
				ael_pkg::M_WS: begin
					if (digit) begin
						sc_mode = ael_pkg::M_INT;
						ok = take_digit(c, 1'b0);
					end else if (c == ael_pkg::CH_DOT)
						sc_mode = ael_pkg::M_DOT;
					else
						ok = 1'b0;  // whitespace may only lead a number
				end
				default: ok = open_token(c);
			endcase
		end
		if (ok && eoe) begin
			if (sc_mode == ael_pkg::M_INT || sc_mode == ael_pkg::M_FRAC)
				close_number();
			else if (sc_mode == ael_pkg::M_WS || sc_mode == ael_pkg::M_DOT)
				ok = 1'b0;
			if (ok) begin
				queue_token(ael_pkg::K_END, '0, '0, 1'b1);
				sc_mode = ael_pkg::M_IDLE;
				drop_number();
				return;
			end
		end
		if (!ok) begin
			queue_token(ael_pkg::K_ERROR, '0, '0, 1'b1);
			drop_number();
			sc_mode = eoe ? ael_pkg::M_IDLE : ael_pkg::M_SKIP;
		end
	endfunction

	// ---------------------------------------------------------------
	// stimulus builders
	// ---------------------------------------------------------------
	function automatic void add_word(logic [7:0] c, logic has, logic eoe);
		char_word_t w;
		w.ch    = c;
		w.has   = has;
		w.eoe   = eoe;
		w.drain = drain_next;
		drain_next = 1'b0;
		chars_to_send.push_back(w);
		if (has || eoe)
			real_words++;
	endfunction

	function automatic void add_text(string s, logic eoe);
		for (int i = 0; i < s.len(); i++)
			add_word(s[i], 1'b1, eoe && (i == s.len() - 1));
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(6))
			0:       return ael_pkg::CH_MINUS;
			1:       return ael_pkg::CH_PLUS;
			2:       return ael_pkg::CH_STAR;
			3:       return ael_pkg::CH_SLASH;
			4:       return ael_pkg::CH_CARET;
			5:       return ael_pkg::CH_LPAREN;
			default: return ael_pkg::CH_RPAREN;
		endcase
	endfunction

	// tab, LF, VT, FF, CR or space
	function automatic logic [7:0] pick_space();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? ael_pkg::CH_SPACE : ael_pkg::CH_TAB + 8'(r);
	endfunction

	function automatic logic [7:0] pick_digit();
		return ael_pkg::CH_0 + 8'($urandom_range(9));
	endfunction

	// a number, mostly short; now and then long enough to reach or pass the digit limit
	function automatic void gen_number();
		int  ni;
		int  nf;
		bit  long_num;
		bit  all_nines;
		long_num  = ($urandom_range(99) < 10);
		all_nines = long_num && ($urandom_range(99) < 35);
		if ($urandom_range(99) < 20)
			add_word(pick_space(), 1'b1, 1'b0);
		ni = long_num ? $urandom_range(15, 20) : $urandom_range(0, 5);
		for (int i = 0; i < ni; i++)
			add_word(all_nines ? ael_pkg::CH_9 : pick_digit(), 1'b1, 1'b0);
		if (ni == 0 || $urandom_range(99) < 40) begin
			add_word(ael_pkg::CH_DOT, 1'b1, 1'b0);
			nf = long_num ? $urandom_range(1, 4) : $urandom_range(1, 4);
			if ($urandom_range(99) < 6)
				nf = $urandom_range(15, 19);
			for (int i = 0; i < nf; i++)
				add_word(all_nines ? ael_pkg::CH_9 : pick_digit(), 1'b1, 1'b0);
		end
	endfunction

	// mostly well-formed expressions, with some noise and broken pieces
	function automatic void gen_expr();
		int ntok;
		int pick;
		ntok = $urandom_range(1, 7);
		for (int t = 0; t < ntok; t++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				gen_number();
			else if (pick < 85)
				add_word(pick_op(), 1'b1, 1'b0);
			else if (pick < 91)
				add_word(8'($urandom_range(255)), 1'b1, 1'b0);
			else if (pick < 95)
				add_word(8'($urandom_range(255)), 1'b0, 1'b0);  // bare word, ignored
			else begin
				case ($urandom_range(3))
					0: begin
						add_word(pick_space(), 1'b1, 1'b0);
						add_word(pick_op(), 1'b1, 1'b0);
					end
					1: begin
						add_word(pick_digit(), 1'b1, 1'b0);
						add_word(ael_pkg::CH_DOT, 1'b1, 1'b0);
						add_word(ael_pkg::CH_DOT, 1'b1, 1'b0);
					end
					2: begin
						add_word(pick_digit(), 1'b1, 1'b0);
						add_word(ael_pkg::CH_DOT, 1'b1, 1'b0);
						add_word(pick_digit(), 1'b1, 1'b0);
						add_word(ael_pkg::CH_DOT, 1'b1, 1'b0);
					end
					default: begin
						add_word(ael_pkg::CH_DOT, 1'b1, 1'b0);
						add_word(pick_op(), 1'b1, 1'b0);
					end
				endcase
			end
		end
		// closing word: bare end mark, or a character that carries the end
		pick = $urandom_range(99);
		if (pick < 35)
			add_word(8'($urandom_range(255)), 1'b0, 1'b1);
		else if (pick < 60)
			add_word(pick_digit(), 1'b1, 1'b1);
		else if (pick < 80)
			add_word(ael_pkg::CH_RPAREN, 1'b1, 1'b1);
		else if (pick < 90)
			add_word(($urandom_range(1) != 0) ? ael_pkg::CH_DOT : pick_space(), 1'b1, 1'b1);
		else
			add_word(8'($urandom_range(255)), 1'b1, 1'b1);
	endfunction

	// ---------------------------------------------------------------
	// clock
	// ---------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// driver: present queued character words, predict on acceptance
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				scan_char(s_tdata, s_tuser, s_tlast);
				words_sent <= words_sent + 1;
			end
			// a word that stays valid is only replaced, never dropped and raised again
			if (!s_tvalid || s_tready) begin
				if (chars_to_send.size() != 0 &&
				    !(chars_to_send[0].drain && tokens_due.size() != 0) &&
				    $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= chars_to_send[0].ch;
					s_tuser  <= chars_to_send[0].has;
					s_tlast  <= chars_to_send[0].eoe;
					void'(chars_to_send.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: random back-pressure, compare each token word in order
	// ---------------------------------------------------------------
	always @(posedge clk) begin : token_monitor
		ael_pkg::tok_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					if (bad_tokens < 10)
						$display("unexpected token: kind %0d mant %0d frac %0d last %0d",
						         m_tuser, m_tdata[ael_pkg::MANT_W-1:0],
						         m_tdata[ael_pkg::MANT_W+ael_pkg::FRAC_W-1:ael_pkg::MANT_W],
						         m_tlast);
					bad_tokens <= bad_tokens + 1;
				end else begin
					want = tokens_due.pop_front();
					if (m_tuser != want.kind || m_tdata[ael_pkg::MANT_W-1:0] != want.mant ||
					    m_tdata[ael_pkg::MANT_W+ael_pkg::FRAC_W-1:ael_pkg::MANT_W] != want.frac ||
					    m_tlast != want.last) begin
						if (bad_tokens < 10)
							$display({"token mismatch: want kind %0d mant %0d frac %0d last %0d,",
							          " got kind %0d mant %0d frac %0d last %0d"},
							         want.kind, want.mant, want.frac, want.last,
							         m_tuser, m_tdata[ael_pkg::MANT_W-1:0],
							         m_tdata[ael_pkg::MANT_W+ael_pkg::FRAC_W-1:ael_pkg::MANT_W],
							         m_tlast);
						bad_tokens <= bad_tokens + 1;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: too long with no word moving on either side
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		// directed: every operator, empty expression, leading whitespace and point
		add_text("-+*/^()", 1'b1);
		add_word(8'h00, 1'b0, 1'b1);
		add_text(" .5", 1'b1);
		add_word(8'hA5, 1'b0, 1'b0);   // bare word, no effect
		add_text("2.", 1'b1);          // point with nothing after it at the end
		add_text("1.2.", 1'b0);        // second point, then skip up to the end
		add_word(8'hFF, 1'b1, 1'b1);
		add_word(8'h00, 1'b1, 1'b1);   // bad character on the closing word
		add_text(" +", 1'b1);          // whitespace not before a number
		add_text("7x", 1'b1);          // number flushed, then bad character

		// random part, with a full drain at its start and once midway
		drain_next = 1'b1;
		begin : random_fill
			int  base;
			bit  mid_done;
			base     = real_words;
			mid_done = 1'b0;
			while (real_words < base + RANDOM_WORDS) begin
				if (!mid_done && real_words >= base + RANDOM_WORDS / 2) begin
					drain_next = 1'b1;
					mid_done   = 1'b1;
				end
				gen_expr();
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (chars_to_send.size() != 0 || s_tvalid || tokens_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_tokens == 0 && tokens_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
